>>> rtl/core/tslf_pkg.sv
// ----------------------------------------------------------------------------
// tslf_pkg
// Shared types, constants and helpers for the text stream line formatter.
// ----------------------------------------------------------------------------
package tslf_pkg;

    localparam int LINE_DIGITS_DEF  = 8;
    localparam int NUMBER_WIDTH_DEF = 6;
    localparam int MAX_OUT          = 14;
    localparam int CFG_IDX_W        = 3;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [6:0] C_SPACE   = 7'd32;
    localparam logic [6:0] C_DEL     = 7'd127;
    localparam logic [7:0] CARET_OFS = 8'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMBER_ALL       = 3'd0,
        CFG_NUMBER_NONBLANK  = 3'd1,
        CFG_SQUEEZE_BLANK    = 3'd2,
        CFG_SHOW_ENDS        = 3'd3,
        CFG_SHOW_TABS        = 3'd4,
        CFG_SHOW_NONPRINTING = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

    // one formatting request, apart from the line number itself
    typedef struct packed {
        logic       num_en;
        logic       dollar;
        logic       mpre;
        logic       caret;
        logic [7:0] ch;
    } cmd_t;

    typedef enum logic [3:0] {
        PH_PAD,
        PH_DIG,
        PH_SP1,
        PH_SP2,
        PH_DOLLAR,
        PH_M,
        PH_DASH,
        PH_CARET,
        PH_CHAR
    } phase_t;

    function automatic phase_t phase_after_mdash(input cmd_t c);
        phase_t p;
        p = c.caret ? PH_CARET : PH_CHAR;
        return p;
    endfunction

    function automatic phase_t phase_after_dollar(input cmd_t c);
        phase_t p;
        p = c.mpre ? PH_M : phase_after_mdash(c);
        return p;
    endfunction

    function automatic phase_t phase_after_num(input cmd_t c);
        phase_t p;
        p = c.dollar ? PH_DOLLAR : phase_after_dollar(c);
        return p;
    endfunction

endpackage

>>> rtl/core/tslf_front.sv
// ----------------------------------------------------------------------------
// tslf_front
// Accepts input bytes, holds configuration and line state, squeezes blank
// lines, keeps the BCD line counter and classifies each byte into a request.
// ----------------------------------------------------------------------------
module tslf_front #(
    parameter int LINE_DIGITS  = tslf_pkg::LINE_DIGITS_DEF,
    parameter int NUMBER_WIDTH = tslf_pkg::NUMBER_WIDTH_DEF,
    localparam int CW = $clog2(((LINE_DIGITS > NUMBER_WIDTH) ? LINE_DIGITS : NUMBER_WIDTH) + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tslf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tuser,
    input  logic                            full,
    output logic                            push,
    output tslf_pkg::cmd_t                  cmd,
    output logic [LINE_DIGITS-1:0][3:0]     num,
    output logic [CW-1:0]                   ndig
);

    localparam logic [LINE_DIGITS*4-1:0] COUNT_ONE = {{(LINE_DIGITS*4-1){1'b0}}, 1'b1};

    tslf_pkg::cfg_t cfg_reg;
    logic prev_nl_reg, prev_nl_next;
    logic [1:0] run_reg, run_next;
    logic [LINE_DIGITS-1:0][3:0] count_reg, count_next;
    logic als_reg, als_next;

    logic accept, is_nl, pn, als, drop, number_it, carry, all9;
    logic [1:0] run, run_n;
    logic [LINE_DIGITS-1:0][3:0] lc, lc_inc;
    logic [6:0] c;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;
    assign push     = accept && !drop;
    assign num      = lc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (tslf_pkg::cfg_idx_t'(cfg_index))
                tslf_pkg::CFG_NUMBER_ALL:       cfg_reg.number_all       <= cfg_data;
                tslf_pkg::CFG_NUMBER_NONBLANK:  cfg_reg.number_nonblank  <= cfg_data;
                tslf_pkg::CFG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg_data;
                tslf_pkg::CFG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg_data;
                tslf_pkg::CFG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg_data;
                tslf_pkg::CFG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg_data;
                default:                        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // line state, with a file start applied first
    always_comb
    begin
        is_nl = (s_tdata == tslf_pkg::CH_NL);
        pn    = s_tuser ? 1'b1 : prev_nl_reg;
        run   = s_tuser ? 2'd0 : run_reg;
        lc    = s_tuser ? COUNT_ONE : count_reg;
        als   = s_tuser ? 1'b1 : als_reg;

        run_n = run;
        drop  = 1'b0;
        if (cfg_reg.squeeze_blank)
        begin
            if (is_nl && pn)
            begin
                run_n = (run == 2'd2) ? 2'd2 : run + 2'd1;
                drop  = (run_n > 2'd1);
            end
            else
            begin
                run_n = 2'd0;
            end
        end

        number_it = als && (cfg_reg.number_nonblank ? !is_nl : cfg_reg.number_all);

        all9 = 1'b1;
        for (int i = 0; i < LINE_DIGITS; i++)
        begin
            all9 = all9 && (lc[i] == 4'd9);
        end
        lc_inc = lc;
        carry  = 1'b1;
        for (int i = 0; i < LINE_DIGITS; i++)
        begin
            if (carry)
            begin
                if (lc[i] == 4'd9)
                begin
                    lc_inc[i] = 4'd0;
                end
                else
                begin
                    lc_inc[i] = lc[i] + 4'd1;
                    carry     = 1'b0;
                end
            end
        end
        if (all9)
        begin
            lc_inc = lc;
        end

        ndig = CW'(1);
        for (int i = 0; i < LINE_DIGITS; i++)
        begin
            if (lc[i] != 4'd0)
            begin
                ndig = CW'(i + 1);
            end
        end
    end

    always_comb
    begin
        prev_nl_next = prev_nl_reg;
        run_next     = run_reg;
        count_next   = count_reg;
        als_next     = als_reg;
        if (accept)
        begin
            run_next = run_n;
            if (drop)
            begin
                prev_nl_next = 1'b1;
                count_next   = lc;
                als_next     = als;
            end
            else
            begin
                prev_nl_next = is_nl;
                count_next   = number_it ? lc_inc : lc;
                als_next     = is_nl;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_nl_reg <= 1'b1;
            run_reg     <= 2'd0;
            count_reg   <= COUNT_ONE;
            als_reg     <= 1'b1;
        end
        else
        begin
            prev_nl_reg <= prev_nl_next;
            run_reg     <= run_next;
            count_reg   <= count_next;
            als_reg     <= als_next;
        end
    end

    // character classification
    always_comb
    begin
        c          = s_tdata[6:0];
        cmd.num_en = number_it;
        cmd.dollar = cfg_reg.show_ends && is_nl;
        cmd.mpre   = 1'b0;
        cmd.caret  = 1'b0;
        cmd.ch     = s_tdata;
        if (cfg_reg.show_nonprinting)
        begin
            cmd.mpre = s_tdata[7];
            cmd.ch   = {1'b0, c};
            if (c < tslf_pkg::C_SPACE)
            begin
                if (!(({1'b0, c} == tslf_pkg::CH_TAB && !cfg_reg.show_tabs) || is_nl))
                begin
                    cmd.caret = 1'b1;
                    cmd.ch    = {1'b0, c} + tslf_pkg::CARET_OFS;
                end
            end
            else if (c == tslf_pkg::C_DEL)
            begin
                cmd.caret = 1'b1;
                cmd.ch    = tslf_pkg::CH_QMARK;
            end
        end
    end

endmodule

>>> rtl/core/tslf_queue.sv
// ----------------------------------------------------------------------------
// tslf_queue
// Two-entry request queue between the front and back ends.
// ----------------------------------------------------------------------------
module tslf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty,
    output logic             full
);

    localparam int DEPTH = 2;

    logic [DEPTH-1:0][WIDTH-1:0] mem_reg;
    logic wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/tslf_back.sv
// ----------------------------------------------------------------------------
// tslf_back
// Expands one request into its output bytes: number padding and digits,
// separator, end marker, M- prefix, caret and the character itself.
// ----------------------------------------------------------------------------
module tslf_back #(
    parameter int LINE_DIGITS  = tslf_pkg::LINE_DIGITS_DEF,
    parameter int NUMBER_WIDTH = tslf_pkg::NUMBER_WIDTH_DEF,
    localparam int CW = $clog2(((LINE_DIGITS > NUMBER_WIDTH) ? LINE_DIGITS : NUMBER_WIDTH) + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    input  tslf_pkg::cmd_t              cmd,
    input  logic [LINE_DIGITS-1:0][3:0] num,
    input  logic [CW-1:0]               ndig,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast
);

    localparam int DIW = $clog2(LINE_DIGITS);
    localparam int EW  = $clog2(tslf_pkg::MAX_OUT);

    tslf_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [CW-1:0] cnt_reg, cnt_next, cur_cnt, cnt_dec;
    logic busy_reg, busy_next;
    logic [EW-1:0] emit_cnt_reg, emit_cnt_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte;
    logic out_last_reg;
    logic advance, emit, last;

    assign advance  = !out_valid_reg || m_tready;
    assign emit     = advance && !empty;
    assign pop      = emit && last;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign cnt_dec  = cur_cnt - CW'(1);

    // current phase: held mid-request, else the first phase of the head request
    always_comb
    begin
        cur_phase = phase_reg;
        cur_cnt   = cnt_reg;
        if (!busy_reg)
        begin
            if (cmd.num_en)
            begin
                if (CW'(NUMBER_WIDTH) > ndig)
                begin
                    cur_phase = tslf_pkg::PH_PAD;
                    cur_cnt   = CW'(NUMBER_WIDTH) - ndig;
                end
                else
                begin
                    cur_phase = tslf_pkg::PH_DIG;
                    cur_cnt   = ndig;
                end
            end
            else
            begin
                cur_phase = tslf_pkg::phase_after_num(cmd);
                cur_cnt   = '0;
            end
        end
        last = (cur_phase == tslf_pkg::PH_CHAR) ||
               (emit_cnt_reg == EW'(tslf_pkg::MAX_OUT - 1));
    end

    // next state
    always_comb
    begin
        phase_next = cur_phase;
        cnt_next   = cur_cnt;
        unique case (cur_phase)
            tslf_pkg::PH_PAD:
            begin
                if (cur_cnt == CW'(1))
                begin
                    phase_next = tslf_pkg::PH_DIG;
                    cnt_next   = ndig;
                end
                else
                begin
                    cnt_next = cnt_dec;
                end
            end
            tslf_pkg::PH_DIG:
            begin
                if (cur_cnt == CW'(1))
                begin
                    phase_next = tslf_pkg::PH_SP1;
                end
                else
                begin
                    cnt_next = cnt_dec;
                end
            end
            tslf_pkg::PH_SP1:    phase_next = tslf_pkg::PH_SP2;
            tslf_pkg::PH_SP2:    phase_next = tslf_pkg::phase_after_num(cmd);
            tslf_pkg::PH_DOLLAR: phase_next = tslf_pkg::phase_after_dollar(cmd);
            tslf_pkg::PH_M:      phase_next = tslf_pkg::PH_DASH;
            tslf_pkg::PH_DASH:   phase_next = tslf_pkg::phase_after_mdash(cmd);
            tslf_pkg::PH_CARET:  phase_next = tslf_pkg::PH_CHAR;
            tslf_pkg::PH_CHAR:   phase_next = tslf_pkg::PH_CHAR;
            default:             phase_next = tslf_pkg::PH_CHAR;
        endcase

        busy_next      = busy_reg;
        emit_cnt_next  = emit_cnt_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            busy_next      = !last;
            emit_cnt_next  = last ? '0 : emit_cnt_reg + EW'(1);
        end
    end

    // outputs
    always_comb
    begin
        unique case (cur_phase)
            tslf_pkg::PH_PAD,
            tslf_pkg::PH_SP1,
            tslf_pkg::PH_SP2:    out_byte = tslf_pkg::CH_SPACE;
            tslf_pkg::PH_DIG:    out_byte = tslf_pkg::CH_ZERO + {4'd0, num[cnt_dec[DIW-1:0]]};
            tslf_pkg::PH_DOLLAR: out_byte = tslf_pkg::CH_DOLLAR;
            tslf_pkg::PH_M:      out_byte = tslf_pkg::CH_M;
            tslf_pkg::PH_DASH:   out_byte = tslf_pkg::CH_DASH;
            tslf_pkg::PH_CARET:  out_byte = tslf_pkg::CH_CARET;
            tslf_pkg::PH_CHAR:   out_byte = cmd.ch;
            default:             out_byte = cmd.ch;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= out_byte;
            out_last_reg <= last;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/text_stream_line_formatter.sv
// ----------------------------------------------------------------------------
// text_stream_line_formatter
// Byte-stream line formatter: blank-line squeeze, line numbering, end
// markers and caret / M- display of non-printing bytes.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the two-entry request queue has
// room. The output side delivers one byte per cycle unless m_tready stalls it;
// an input byte that formats to n bytes (1 to 14) holds the back end for all
// n, and a plain byte stream runs at one byte per cycle end to end while
// unstalled. A squeezed newline produces no output. Configuration writes
// take effect on the next cycle and must be made while the stream is idle.
module text_stream_line_formatter #(
    parameter int LINE_DIGITS  = tslf_pkg::LINE_DIGITS_DEF,
    parameter int NUMBER_WIDTH = tslf_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tslf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // data_byte
    input  logic                           s_tuser,   // file_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // out_byte
    output logic                           m_tlast    // last_of_run
);

    localparam int CW = $clog2(((LINE_DIGITS > NUMBER_WIDTH) ? LINE_DIGITS : NUMBER_WIDTH) + 1);
    localparam int CMD_W = $bits(tslf_pkg::cmd_t);
    localparam int QW = CMD_W + LINE_DIGITS * 4 + CW;

    tslf_pkg::cmd_t f_cmd, b_cmd;
    logic [LINE_DIGITS-1:0][3:0] f_num, b_num;
    logic [CW-1:0] f_ndig, b_ndig;
    logic push, pop, empty, full;
    logic [QW-1:0] q_din, q_dout;

    assign q_din  = {f_cmd, f_num, f_ndig};
    assign b_cmd  = q_dout[QW-1 -: CMD_W];
    assign b_num  = q_dout[CW +: LINE_DIGITS*4];
    assign b_ndig = q_dout[CW-1:0];

    tslf_front #(
        .LINE_DIGITS  (LINE_DIGITS),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .full      (full),
        .push      (push),
        .cmd       (f_cmd),
        .num       (f_num),
        .ndig      (f_ndig)
    );

    tslf_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .pop   (pop),
        .dout  (q_dout),
        .empty (empty),
        .full  (full)
    );

    tslf_back #(
        .LINE_DIGITS  (LINE_DIGITS),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .cmd      (b_cmd),
        .num      (b_num),
        .ndig     (b_ndig),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/core/tslf_checker.sv
// ----------------------------------------------------------------------------
// tslf_checker
// Port-level checks for the text stream line formatter, bound to the top.
// ----------------------------------------------------------------------------
module tslf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // no output request while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    // stalled output request holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output request changed");

    // bytes of one run come without gaps
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an output run");

    // input back-pressure only while output is pending
    a_bp_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with nothing pending on output");

endmodule

bind text_stream_line_formatter tslf_checker u_tslf_checker (.*);

>>> tb/sv/text_stream_line_formatter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_stream_line_formatter_test
// Self-checking bench for the line formatter. Bytes go in on the slave stream
// and every accepted request is run through a local formatter model; each
// byte from the master stream is checked against the oldest predicted byte.
// Directed cases cover raw bytes, caret and M- display, numbering and blank
// squeeze, then random text runs under a range of settings, with random
// stalls on both sides and one long hold-off at the output.
// ----------------------------------------------------------------------------
module text_stream_line_formatter_test;

    localparam int LINE_DIGITS  = tslf_pkg::LINE_DIGITS_DEF;
    localparam int NUMBER_WIDTH = tslf_pkg::NUMBER_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 16;

    typedef struct {
        logic [7:0] ch;
        logic       is_last;
    } fmt_char_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [tslf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic                           cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;   // data_byte
    logic                           s_tuser;   // file_start
    logic                           m_tvalid;
    logic                           m_tready;
    logic [7:0]                     m_tdata;   // out_byte
    logic                           m_tlast;   // last_of_run

    // formatter model state
    tslf_pkg::cfg_t fmt_cfg;
    logic           nl_before;
    logic [1:0]     nl_run;
    logic [63:0]    line_bcd;
    logic           line_fresh;
    fmt_char_t      fmt_due[$];

    int tx_gap_max;
    int rx_gap_max;
    int rx_wait;
    int rx_hold;
    int requests_in;
    int bytes_checked;
    int settings_used;
    int errors;

    text_stream_line_formatter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap(input int max_gap);
        if (max_gap == 0 || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, max_gap);
    endfunction

    // ------------------------------------------------------------------
    // model: formatted bytes for one input byte
    // ------------------------------------------------------------------
    function automatic void format_byte(input logic [7:0] b, input logic fs);
        logic [7:0] seq[$];
        logic       is_nl;
        logic       number_it;
        logic       all_nines;
        logic [7:0] c;
        logic [3:0] d;
        int         ndig;
        int         n;
        fmt_char_t  item;

        is_nl = (b == tslf_pkg::CH_NL);
        if (fs)
        begin
            nl_before  = 1'b1;
            nl_run     = 2'd0;
            line_bcd   = 64'd1;
            line_fresh = 1'b1;
        end

        if (fmt_cfg.squeeze_blank)
        begin
            if (is_nl && nl_before)
            begin
                if (nl_run < 2'd2)
                    nl_run++;
                if (nl_run > 2'd1)
                    return;     // dropped blank line
            end
            else
                nl_run = 2'd0;
        end

        if (line_fresh)
        begin
            number_it = fmt_cfg.number_nonblank ? !is_nl : fmt_cfg.number_all;
            if (number_it)
            begin
                ndig = 1;
                for (int i = 0; i < LINE_DIGITS; i++)
                    if (line_bcd[4*i +: 4] != 4'd0)
                        ndig = i + 1;
                for (int i = ndig; i < NUMBER_WIDTH; i++)
                    seq.push_back(tslf_pkg::CH_SPACE);
                for (int i = ndig - 1; i >= 0; i--)
                    seq.push_back(tslf_pkg::CH_ZERO + line_bcd[4*i +: 4]);
                seq.push_back(tslf_pkg::CH_SPACE);
                seq.push_back(tslf_pkg::CH_SPACE);

                // BCD increment, held at all nines
                all_nines = 1'b1;
                for (int i = 0; i < LINE_DIGITS; i++)
                    if (line_bcd[4*i +: 4] != 4'd9)
                        all_nines = 1'b0;
                if (!all_nines)
                begin
                    for (int i = 0; i < LINE_DIGITS; i++)
                    begin
                        d = line_bcd[4*i +: 4];
                        if (d < 4'd9)
                        begin
                            line_bcd[4*i +: 4] = d + 4'd1;
                            break;
                        end
                        line_bcd[4*i +: 4] = 4'd0;
                    end
                end
            end
            line_fresh = 1'b0;
        end

        if (fmt_cfg.show_ends && is_nl)
            seq.push_back(tslf_pkg::CH_DOLLAR);

        if (fmt_cfg.show_nonprinting)
        begin
            c = b;
            if (c >= 8'd128)
            begin
                seq.push_back(tslf_pkg::CH_M);
                seq.push_back(tslf_pkg::CH_DASH);
                c = c - 8'd128;
            end
            if (c < 8'(tslf_pkg::C_SPACE))
            begin
                if ((c == tslf_pkg::CH_TAB && !fmt_cfg.show_tabs) ||
                    (c == tslf_pkg::CH_NL && is_nl))
                    seq.push_back(c);
                else
                begin
                    seq.push_back(tslf_pkg::CH_CARET);
                    seq.push_back(c + tslf_pkg::CARET_OFS);
                end
            end
            else if (c == 8'(tslf_pkg::C_DEL))
            begin
                seq.push_back(tslf_pkg::CH_CARET);
                seq.push_back(tslf_pkg::CH_QMARK);
            end
            else
                seq.push_back(c);
        end
        else
            seq.push_back(b);

        if (is_nl)
            line_fresh = 1'b1;
        nl_before = is_nl;

        n = (seq.size() > tslf_pkg::MAX_OUT) ? tslf_pkg::MAX_OUT : seq.size();
        for (int i = 0; i < n; i++)
        begin
            item.ch      = seq[i];
            item.is_last = (i == n - 1);
            fmt_due.push_back(item);
        end
    endfunction

    // ------------------------------------------------------------------
    // request capture and output check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        fmt_char_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                format_byte(s_tdata, s_tuser);
                requests_in++;
            end
            if (m_tvalid && m_tready)
            begin
                rx_wait = pick_gap(rx_gap_max);
                if (fmt_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected byte, actual %02h last %0b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = fmt_due.pop_front();
                    bytes_checked++;
                    if (m_tdata !== want.ch)
                    begin
                        errors++;
                        $display("%0t: out_byte mismatch, expected %02h actual %02h",
                                 $time, want.ch, m_tdata);
                    end
                    if (m_tlast !== want.is_last)
                    begin
                        errors++;
                        $display("%0t: last_of_run mismatch, expected %0b actual %0b",
                                 $time, want.is_last, m_tlast);
                    end
                end
            end
        end
    end

    // output side: per-byte stalls plus an optional long hold-off
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait--;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout, %0d bytes still due", $time, fmt_due.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // driving tasks, entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = pick_gap(tx_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fs;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic end_batch();
        s_tvalid <= 1'b0;
        while (fmt_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apply_config(input tslf_pkg::cfg_t c);
        tslf_pkg::cfg_idx_t idx_list[6];
        logic               val_list[6];
        idx_list = '{tslf_pkg::CFG_NUMBER_ALL, tslf_pkg::CFG_NUMBER_NONBLANK,
                     tslf_pkg::CFG_SQUEEZE_BLANK, tslf_pkg::CFG_SHOW_ENDS,
                     tslf_pkg::CFG_SHOW_TABS, tslf_pkg::CFG_SHOW_NONPRINTING};
        val_list = '{c.number_all, c.number_nonblank, c.squeeze_blank,
                     c.show_ends, c.show_tabs, c.show_nonprinting};
        end_batch();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            @(negedge clk);
        end
        cfg_we  <= 1'b0;
        fmt_cfg = c;
        settings_used++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] random_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18)
            return tslf_pkg::CH_NL;
        if (r < 23)
            return tslf_pkg::CH_TAB;
        if (r < 60)
            return 8'($urandom_range(32, 126));
        if (r < 70)
            return 8'($urandom_range(0, 31));
        if (r < 73)
            return 8'd127;
        if (r < 76)
            return 8'h8A;
        if (r < 78)
            return 8'h89;
        return 8'($urandom_range(128, 255));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_raw_bytes();
        apply_config('0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(tslf_pkg::CH_TAB, 1'b0);
        send_byte(tslf_pkg::CH_NL, 1'b0);
    endtask

    task automatic test_caret_display();
        tslf_pkg::cfg_t c;
        c = '0;
        c.show_nonprinting = 1'b1;
        apply_config(c);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h89, 1'b0);     // M- then raw tab
        send_byte(8'h8A, 1'b0);     // M-^J, line stays open
        send_byte(8'hFF, 1'b0);
        c.show_tabs = 1'b1;
        apply_config(c);
        send_byte(tslf_pkg::CH_TAB, 1'b0);
        send_byte(8'h89, 1'b0);
    endtask

    task automatic test_line_numbers();
        tslf_pkg::cfg_t c;
        c = '0;
        c.number_all = 1'b1;
        c.show_ends  = 1'b1;
        apply_config(c);
        send_byte("a", 1'b1);
        send_byte(tslf_pkg::CH_NL, 1'b0);
        send_byte(tslf_pkg::CH_NL, 1'b0);
        send_byte("b", 1'b0);
        // nonblank wins over number_all, blank lines go unnumbered
        c.number_nonblank = 1'b1;
        apply_config(c);
        send_byte(tslf_pkg::CH_NL, 1'b1);
        send_byte("c", 1'b0);
        send_byte(tslf_pkg::CH_NL, 1'b0);
    endtask

    task automatic test_blank_squeeze();
        tslf_pkg::cfg_t c;
        c = '0;
        c.squeeze_blank = 1'b1;
        c.number_all    = 1'b1;
        apply_config(c);
        // a file start counts as a newline already seen
        send_byte(tslf_pkg::CH_NL, 1'b1);
        send_byte(tslf_pkg::CH_NL, 1'b0);
        send_byte("x", 1'b0);
        send_byte(tslf_pkg::CH_NL, 1'b0);
        send_byte(tslf_pkg::CH_NL, 1'b0);
        send_byte(tslf_pkg::CH_NL, 1'b0);
        send_byte(tslf_pkg::CH_NL, 1'b1);
    endtask

    task automatic test_random_text();
        tslf_pkg::cfg_t c;
        int             len;
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 0)
                c = '0;
            else if (ph == 1)
                c = '1;
            else
                c = tslf_pkg::cfg_t'(6'($urandom_range(0, 63)));
            apply_config(c);
            tx_gap_max = (ph % 3 == 2) ? 0 : 16;
            rx_gap_max = (ph % 3 == 1) ? 0 : 16;
            len = $urandom_range(9, 15);
            for (int i = 0; i < len; i++)
                send_byte(random_text_byte(),
                          (i == 0) ? 1'($urandom_range(0, 1)) :
                          ($urandom_range(0, 24) == 0));
        end
    endtask

    task automatic test_output_hold();
        tslf_pkg::cfg_t c;
        c = '0;
        c.number_all       = 1'b1;
        c.show_nonprinting = 1'b1;
        c.show_ends        = 1'b1;
        apply_config(c);
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold    = 400;
        for (int i = 0; i < 24; i++)
            send_byte(($urandom_range(0, 2) == 0) ? tslf_pkg::CH_NL :
                      8'($urandom_range(128, 255)),
                      i == 0);
        rx_gap_max = 16;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = tslf_pkg::CFG_NUMBER_ALL;
        cfg_data      = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        fmt_cfg       = '0;
        nl_before     = 1'b1;
        nl_run        = 2'd0;
        line_bcd      = 64'd1;
        line_fresh    = 1'b1;
        tx_gap_max    = 16;
        rx_gap_max    = 16;
        rx_wait       = 0;
        rx_hold       = 0;
        requests_in   = 0;
        bytes_checked = 0;
        settings_used = 0;
        errors        = 0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_raw_bytes();
        test_caret_display();
        test_line_numbers();
        test_blank_squeeze();
        test_random_text();
        test_output_hold();
        end_batch();

        $display("%0d input bytes under %0d settings, %0d output bytes checked",
                 requests_in, settings_used, bytes_checked);
        $display("covered caret/M- display, numbering, squeeze and output hold-off");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
